/* rtl/core/alle_pkg.sv */
// Shared types, constants and link reset functions for the array linked list engine.
// No dependencies; the other files in rtl/core but alle_ram refer to it by scoped name.
package alle_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W       = SLOT_W + 1;

   typedef enum logic [2:0] {
      OP_INS_HEAD   = 3'd0,
      OP_INS_TAIL   = 3'd1,
      OP_INS_AFTER  = 3'd2,
      OP_INS_BEFORE = 3'd3,
      OP_DELETE     = 3'd4,
      OP_LOOKUP     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      K_HEAD,
      K_TAIL,
      K_AFTER
   } kind_type;

   typedef enum logic [4:0] {
      S_IDLE, S_TF_RD, S_TF_WR, S_H2, S_T2, S_A2, S_A3, S_A4, S_B1, S_B2,
      S_DT1, S_DT2, S_DH1, S_DH2, S_DM1, S_DM2, S_F1, S_F2,
      S_W_RD, S_W_STEP, S_DONE
   } state_type;

   typedef struct packed {
      op_type                         opcode;
      logic signed [VALUE_WIDTH-1:0]  item_value;
      logic [SLOT_W-1:0]              slot_ref;
      logic [SLOT_W-1:0]              position;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      status_type        status;
   } rsp_item_type;

   // accesses from the sequencer to the slot store
   typedef struct packed {
      logic [SLOT_W-1:0]      nxt_rd_addr;
      logic [SLOT_W-1:0]      prv_rd_addr;
      logic                   nxt_we;
      logic [SLOT_W-1:0]      nxt_wa;
      logic [SLOT_W-1:0]      nxt_wd;
      logic                   prv_we;
      logic [SLOT_W-1:0]      prv_wa;
      logic [SLOT_W-1:0]      prv_wd;
      logic                   val_we;
      logic [SLOT_W-1:0]      val_wa;
      logic [VALUE_WIDTH-1:0] val_wd;
   } store_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] nxt_q;
      logic [SLOT_W-1:0] prv_q;
   } store_rsp_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } done_type;

   // free chain after reset: slot i to i+1, last slot to itself, sentinel to 0
   function automatic logic [SLOT_W-1:0] next_reset(input logic [SLOT_W-1:0] a);
      logic [SLOT_W-1:0] r;
      if (a == '0) begin
         r = '0;
      end else if (a == SLOT_W'(SLOT_COUNT - 1)) begin
         r = a;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] prev_reset(input logic [SLOT_W-1:0] a);
      logic [SLOT_W-1:0] r;
      r = (a == '0) ? '0 : a - 1'b1;
      return r;
   endfunction

endpackage

/* rtl/core/array_linked_list_engine_top.sv */
// Top level of the array linked list engine: sequencer, slot store and result register.
// Depends on alle_pkg, alle_ctrl, alle_slot_store (and through it alle_ram).
//
// A doubly linked list lives in 64 slots; slot 0 is a sentinel and unused slots
// form a free chain. Each request transaction carries one opcode (insert at head,
// at tail, after a slot, before a slot, delete a slot, look up the n-th element)
// and yields exactly one response transaction with a slot and a status. One
// transaction is worked at a time; its cost is set by the link RAM steps it needs,
// each read being registered. A lookup once the list is no longer linear walks the
// next links from the head to reach position n. The response sits in its own
// register, so a new request is taken while the last response is still stalled.
// After reset the links read as the initial free chain straight away; no clearing
// pass is needed. Slot references naming free slots are not checked and may
// corrupt the list, but the block stays well defined.
module array_linked_list_engine_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  alle_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output alle_pkg::rsp_item_type rsp_item
);

   alle_pkg::store_req_type sreq;
   alle_pkg::store_rsp_type srsp;
   alle_pkg::done_type      done;
   logic                    out_free;
   logic                    rsp_valid_ff, rsp_valid_in;
   alle_pkg::rsp_item_type  rsp_item_ff, rsp_item_in;

   alle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .out_free  (out_free),
      .done      (done),
      .sreq      (sreq),
      .srsp      (srsp)
   );

   alle_slot_store u_store (
      .clock (clock),
      .reset (reset),
      .sreq  (sreq),
      .srsp  (srsp)
   );

   // response register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (done.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = done.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* rtl/core/alle_ram.sv */
// Generic single write, single read port RAM with registered read data.
// No dependencies.
module alle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/alle_slot_store.sv */
// Slot store: next links, previous links and element values in three RAMs.
// Valid bits stand in for the link reset pattern. Depends on alle_pkg, alle_ram.
module alle_slot_store (
   input  logic                   clock,
   input  logic                   reset,
   input  alle_pkg::store_req_type sreq,
   output alle_pkg::store_rsp_type srsp
);

   logic [alle_pkg::SLOT_COUNT-1:0] nxt_vld_ff, nxt_vld_in;
   logic [alle_pkg::SLOT_COUNT-1:0] prv_vld_ff, prv_vld_in;
   logic                            nxt_vq_ff, prv_vq_ff;
   logic [alle_pkg::SLOT_W-1:0]     nxt_aq_ff, prv_aq_ff;
   logic [alle_pkg::SLOT_W-1:0]     nxt_ram_q, prv_ram_q;

   alle_ram #(.WIDTH(alle_pkg::SLOT_W), .DEPTH(alle_pkg::SLOT_COUNT)) u_next_ram (
      .clock   (clock),
      .wr_en   (sreq.nxt_we),
      .wr_addr (sreq.nxt_wa),
      .wr_data (sreq.nxt_wd),
      .rd_addr (sreq.nxt_rd_addr),
      .rd_data (nxt_ram_q)
   );

   alle_ram #(.WIDTH(alle_pkg::SLOT_W), .DEPTH(alle_pkg::SLOT_COUNT)) u_prev_ram (
      .clock   (clock),
      .wr_en   (sreq.prv_we),
      .wr_addr (sreq.prv_wa),
      .wr_data (sreq.prv_wd),
      .rd_addr (sreq.prv_rd_addr),
      .rd_data (prv_ram_q)
   );

   // values are stored only; no result reads them back
   alle_ram #(.WIDTH(alle_pkg::VALUE_WIDTH), .DEPTH(alle_pkg::SLOT_COUNT)) u_value_ram (
      .clock   (clock),
      .wr_en   (sreq.val_we),
      .wr_addr (sreq.val_wa),
      .wr_data (sreq.val_wd),
      .rd_addr (sreq.val_wa),
      .rd_data ()
   );

   always_comb begin
      nxt_vld_in = nxt_vld_ff;
      prv_vld_in = prv_vld_ff;
      if (sreq.nxt_we) begin
         nxt_vld_in[sreq.nxt_wa] = 1'b1;
      end
      if (sreq.prv_we) begin
         prv_vld_in[sreq.prv_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_vld_ff <= '0;
         prv_vld_ff <= '0;
      end else begin
         nxt_vld_ff <= nxt_vld_in;
         prv_vld_ff <= prv_vld_in;
      end
      // sampled with the RAM read, so both show the state before this edge
      nxt_vq_ff <= nxt_vld_ff[sreq.nxt_rd_addr];
      prv_vq_ff <= prv_vld_ff[sreq.prv_rd_addr];
      nxt_aq_ff <= sreq.nxt_rd_addr;
      prv_aq_ff <= sreq.prv_rd_addr;
   end

   assign srsp.nxt_q = nxt_vq_ff ? nxt_ram_q : alle_pkg::next_reset(nxt_aq_ff);
   assign srsp.prv_q = prv_vq_ff ? prv_ram_q : alle_pkg::prev_reset(prv_aq_ff);

endmodule

/* rtl/core/alle_ctrl.sv */
// Sequencer: decodes a transaction, walks the read-modify-write steps on the
// slot store and keeps head, tail, free pointer, count and linear flag.
// Depends on alle_pkg.
module alle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  alle_pkg::req_item_type  req_item,
   input  logic                    out_free,
   output alle_pkg::done_type      done,
   output alle_pkg::store_req_type sreq,
   input  alle_pkg::store_rsp_type srsp
);

   alle_pkg::state_type          state_ff, state_in;
   alle_pkg::kind_type           kind_ff, kind_in;
   logic [alle_pkg::VALUE_WIDTH-1:0] val_ff, val_in;
   logic [alle_pkg::SLOT_W-1:0]  ref_ff, ref_in;
   logic [alle_pkg::SLOT_W-1:0]  s_ff, s_in;
   logic [alle_pkg::SLOT_W-1:0]  a_ff, a_in;
   logic [alle_pkg::SLOT_W-1:0]  walk_ff, walk_in;
   logic [alle_pkg::SLOT_W-1:0]  cur_ff, cur_in;
   logic [alle_pkg::SLOT_W-1:0]  head_ff, head_in;
   logic [alle_pkg::SLOT_W-1:0]  tail_ff, tail_in;
   logic [alle_pkg::SLOT_W-1:0]  free_ff, free_in;
   logic [alle_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         lin_ff, lin_in;
   logic [alle_pkg::SLOT_W-1:0]  res_slot_ff, res_slot_in;
   alle_pkg::status_type         res_st_ff, res_st_in;
   logic                         full, empty;

   assign full  = cnt_ff >= alle_pkg::CNT_W'(alle_pkg::SLOT_COUNT - 1);
   assign empty = cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alle_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         free_ff  <= alle_pkg::SLOT_W'(1);
         cnt_ff   <= '0;
         lin_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         cnt_ff   <= cnt_in;
         lin_ff   <= lin_in;
      end
      kind_ff     <= kind_in;
      val_ff      <= val_in;
      ref_ff      <= ref_in;
      s_ff        <= s_in;
      a_ff        <= a_in;
      walk_ff     <= walk_in;
      cur_ff      <= cur_in;
      res_slot_ff <= res_slot_in;
      res_st_ff   <= res_st_in;
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      val_in      = val_ff;
      ref_in      = ref_ff;
      s_in        = s_ff;
      a_in        = a_ff;
      walk_in     = walk_ff;
      cur_in      = cur_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      cnt_in      = cnt_ff;
      lin_in      = lin_ff;
      res_slot_in = res_slot_ff;
      res_st_in   = res_st_ff;
      sreq        = '0;
      req_stall   = 1'b1;
      done.valid  = 1'b0;
      done.item.slot_out = res_slot_ff;
      done.item.status   = res_st_ff;

      unique case (state_ff)
         alle_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            val_in      = req_item.item_value;
            ref_in      = req_item.slot_ref;
            res_slot_in = '0;
            res_st_in   = alle_pkg::ST_OK;
            if (req_valid) begin
               state_in = alle_pkg::S_DONE;
               unique case (req_item.opcode)
                  alle_pkg::OP_INS_HEAD, alle_pkg::OP_INS_TAIL: begin
                     if (full) begin
                        res_st_in = alle_pkg::ST_FULL;
                     end else begin
                        kind_in  = (req_item.opcode == alle_pkg::OP_INS_HEAD) ?
                                   alle_pkg::K_HEAD : alle_pkg::K_TAIL;
                        state_in = alle_pkg::S_TF_RD;
                     end
                  end
                  alle_pkg::OP_INS_AFTER, alle_pkg::OP_INS_BEFORE: begin
                     if (full) begin
                        res_st_in = alle_pkg::ST_FULL;
                     end else if (empty) begin
                        res_st_in = alle_pkg::ST_EMPTY;
                     end else if (req_item.slot_ref == '0) begin
                        res_st_in = alle_pkg::ST_RANGE;
                     end else if (req_item.opcode == alle_pkg::OP_INS_AFTER) begin
                        kind_in  = (req_item.slot_ref == tail_ff) ?
                                   alle_pkg::K_TAIL : alle_pkg::K_AFTER;
                        state_in = alle_pkg::S_TF_RD;
                     end else if (req_item.slot_ref == head_ff) begin
                        kind_in  = alle_pkg::K_HEAD;
                        state_in = alle_pkg::S_TF_RD;
                     end else begin
                        state_in = alle_pkg::S_B1;
                     end
                  end
                  alle_pkg::OP_DELETE: begin
                     if (empty) begin
                        res_st_in = alle_pkg::ST_EMPTY;
                     end else if (req_item.slot_ref == '0) begin
                        res_st_in = alle_pkg::ST_RANGE;
                     end else if (cnt_ff == alle_pkg::CNT_W'(1)) begin
                        head_in  = '0;
                        tail_in  = '0;
                        state_in = alle_pkg::S_F1;
                     end else if (req_item.slot_ref == tail_ff) begin
                        state_in = alle_pkg::S_DT1;
                     end else if (req_item.slot_ref == head_ff) begin
                        state_in = alle_pkg::S_DH1;
                     end else begin
                        state_in = alle_pkg::S_DM1;
                     end
                  end
                  alle_pkg::OP_LOOKUP: begin
                     if (empty) begin
                        res_st_in = alle_pkg::ST_EMPTY;
                     end else if (req_item.position == '0 ||
                                  {1'b0, req_item.position} > cnt_ff) begin
                        res_st_in = alle_pkg::ST_RANGE;
                     end else if (lin_ff) begin
                        res_slot_in = req_item.position;
                     end else if (req_item.position == alle_pkg::SLOT_W'(1)) begin
                        res_slot_in = head_ff;
                     end else begin
                        walk_in  = req_item.position - 1'b1;
                        cur_in   = head_ff;
                        state_in = alle_pkg::S_W_RD;
                     end
                  end
                  default: begin
                     res_st_in = alle_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         // take a slot off the free chain
         alle_pkg::S_TF_RD: begin
            sreq.nxt_rd_addr = free_ff;
            state_in         = alle_pkg::S_TF_WR;
         end
         alle_pkg::S_TF_WR: begin
            s_in        = free_ff;
            free_in     = srsp.nxt_q;
            sreq.val_we = 1'b1;
            sreq.val_wa = free_ff;
            sreq.val_wd = val_ff;
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = free_ff;
            sreq.prv_we = 1'b1;
            sreq.prv_wa = free_ff;
            res_slot_in = free_ff;
            if (empty) begin
               head_in  = free_ff;
               tail_in  = free_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = alle_pkg::S_DONE;
            end else begin
               unique case (kind_ff)
                  alle_pkg::K_HEAD: state_in = alle_pkg::S_H2;
                  alle_pkg::K_TAIL: state_in = alle_pkg::S_T2;
                  default:          state_in = alle_pkg::S_A2;
               endcase
            end
         end
         alle_pkg::S_H2: begin
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = s_ff;
            sreq.nxt_wd = head_ff;
            sreq.prv_we = 1'b1;
            sreq.prv_wa = head_ff;
            sreq.prv_wd = s_ff;
            head_in     = s_ff;
            lin_in      = 1'b0;
            cnt_in      = cnt_ff + 1'b1;
            state_in    = alle_pkg::S_DONE;
         end
         alle_pkg::S_T2: begin
            sreq.prv_we = 1'b1;
            sreq.prv_wa = s_ff;
            sreq.prv_wd = tail_ff;
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = tail_ff;
            sreq.nxt_wd = s_ff;
            tail_in     = s_ff;
            cnt_in      = cnt_ff + 1'b1;
            state_in    = alle_pkg::S_DONE;
         end
         alle_pkg::S_A2: begin
            sreq.nxt_rd_addr = ref_ff;
            state_in         = alle_pkg::S_A3;
         end
         alle_pkg::S_A3: begin
            a_in        = srsp.nxt_q;
            sreq.prv_we = 1'b1;
            sreq.prv_wa = srsp.nxt_q;
            sreq.prv_wd = s_ff;
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = ref_ff;
            sreq.nxt_wd = s_ff;
            state_in    = alle_pkg::S_A4;
         end
         alle_pkg::S_A4: begin
            sreq.prv_we = 1'b1;
            sreq.prv_wa = s_ff;
            sreq.prv_wd = ref_ff;
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = s_ff;
            sreq.nxt_wd = a_ff;
            lin_in      = 1'b0;
            cnt_in      = cnt_ff + 1'b1;
            state_in    = alle_pkg::S_DONE;
         end
         // insert before: becomes insert after the left neighbour
         alle_pkg::S_B1: begin
            sreq.prv_rd_addr = ref_ff;
            state_in         = alle_pkg::S_B2;
         end
         alle_pkg::S_B2: begin
            ref_in   = srsp.prv_q;
            kind_in  = (srsp.prv_q == tail_ff) ? alle_pkg::K_TAIL : alle_pkg::K_AFTER;
            state_in = alle_pkg::S_TF_RD;
         end
         alle_pkg::S_DT1: begin
            sreq.prv_rd_addr = tail_ff;
            state_in         = alle_pkg::S_DT2;
         end
         alle_pkg::S_DT2: begin
            tail_in     = srsp.prv_q;
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = srsp.prv_q;
            state_in    = alle_pkg::S_F1;
         end
         alle_pkg::S_DH1: begin
            sreq.nxt_rd_addr = head_ff;
            state_in         = alle_pkg::S_DH2;
         end
         alle_pkg::S_DH2: begin
            head_in     = srsp.nxt_q;
            sreq.prv_we = 1'b1;
            sreq.prv_wa = srsp.nxt_q;
            lin_in      = 1'b0;
            state_in    = alle_pkg::S_F1;
         end
         alle_pkg::S_DM1: begin
            sreq.nxt_rd_addr = ref_ff;
            sreq.prv_rd_addr = ref_ff;
            state_in         = alle_pkg::S_DM2;
         end
         alle_pkg::S_DM2: begin
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = srsp.prv_q;
            sreq.nxt_wd = srsp.nxt_q;
            sreq.prv_we = 1'b1;
            sreq.prv_wa = srsp.nxt_q;
            sreq.prv_wd = srsp.prv_q;
            lin_in      = 1'b0;
            state_in    = alle_pkg::S_F1;
         end
         // return the deleted slot to the front of the free chain
         alle_pkg::S_F1: begin
            sreq.prv_we = 1'b1;
            sreq.prv_wa = free_ff;
            sreq.prv_wd = ref_ff;
            sreq.nxt_we = 1'b1;
            sreq.nxt_wa = ref_ff;
            sreq.nxt_wd = free_ff;
            state_in    = alle_pkg::S_F2;
         end
         alle_pkg::S_F2: begin
            sreq.prv_we = 1'b1;
            sreq.prv_wa = ref_ff;
            free_in     = ref_ff;
            cnt_in      = cnt_ff - 1'b1;
            res_slot_in = ref_ff;
            state_in    = alle_pkg::S_DONE;
         end
         alle_pkg::S_W_RD: begin
            sreq.nxt_rd_addr = cur_ff;
            state_in         = alle_pkg::S_W_STEP;
         end
         alle_pkg::S_W_STEP: begin
            cur_in  = srsp.nxt_q;
            walk_in = walk_ff - 1'b1;
            if (walk_ff == alle_pkg::SLOT_W'(1)) begin
               res_slot_in = srsp.nxt_q;
               state_in    = alle_pkg::S_DONE;
            end else begin
               state_in    = alle_pkg::S_W_RD;
            end
         end
         alle_pkg::S_DONE: begin
            done.valid = 1'b1;
            if (out_free) begin
               state_in = alle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = alle_pkg::S_IDLE;
         end
      endcase
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= alle_pkg::CNT_W'(alle_pkg::SLOT_COUNT - 1))
      else $error("element count above capacity");

   a_lin_sticky: assert property (@(posedge clock) disable iff (reset)
      !lin_ff |=> !lin_ff)
      else $error("linear flag set again");

   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      done.valid && done.item.status != alle_pkg::ST_OK |-> done.item.slot_out == '0)
      else $error("failed transaction reports a slot");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != alle_pkg::S_IDLE |=> cnt_ff == $past(cnt_ff) ||
         cnt_ff == $past(cnt_ff) + 1'b1 || cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("element count jumped");

endmodule

/* tb/sv/array_linked_list_engine_top_tb.sv */
// Testbench for array_linked_list_engine_top: directed and random list operations,
// checked against an in-bench model of the slot links. Depends on alle_pkg and array_linked_list_engine_top.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the list state and a queue of expected responses.
class list_scoreboard;
   int unsigned nxt [alle_pkg::SLOT_COUNT];
   int unsigned prv [alle_pkg::SLOT_COUNT];
   int unsigned head, tail, free_ptr, count;
   bit linear;
   alle_pkg::rsp_item_type pending_rsp[$];
   int errors;
   int n_ok, n_full, n_empty, n_range;

   function new();
      for (int i = 0; i < alle_pkg::SLOT_COUNT; i++) begin
         nxt[i] = (i == 0) ? 0 : ((i + 1 < alle_pkg::SLOT_COUNT) ? i + 1 : i);
         prv[i] = (i > 0) ? i - 1 : 0;
      end
      head = 0; tail = 0; free_ptr = 1; count = 0; linear = 1;
      errors = 0;
   endfunction

   function int unsigned pop_free();
      int unsigned s;
      s = free_ptr % alle_pkg::SLOT_COUNT;
      free_ptr = nxt[s];
      nxt[s] = 0;
      prv[s] = 0;
      return s;
   endfunction

   function int unsigned put_head();
      int unsigned s;
      s = pop_free();
      if (count == 0) begin
         head = s; tail = s;
      end else begin
         nxt[s] = head; prv[head] = s; head = s; linear = 0;
      end
      count++;
      return s;
   endfunction

   function int unsigned put_tail();
      int unsigned s;
      s = pop_free();
      if (count == 0) begin
         head = s; tail = s;
      end else begin
         prv[s] = tail; nxt[tail] = s; tail = s;
      end
      count++;
      return s;
   endfunction

   function int unsigned put_after(int unsigned r);
      int unsigned s, right;
      if (r == tail) return put_tail();
      s = pop_free();
      right = nxt[r];
      prv[right] = s; nxt[r] = s; prv[s] = r; nxt[s] = right;
      linear = 0;
      count++;
      return s;
   endfunction

   function void unlink(int unsigned e);
      if (count == 1) begin
         head = 0; tail = 0;
      end else if (e == tail) begin
         tail = prv[tail]; nxt[tail] = 0;
      end else if (e == head) begin
         head = nxt[head]; prv[head] = 0; linear = 0;
      end else begin
         nxt[prv[e]] = nxt[e];
         prv[nxt[e]] = prv[e];
         linear = 0;
      end
      prv[free_ptr % alle_pkg::SLOT_COUNT] = e;
      nxt[e] = free_ptr % alle_pkg::SLOT_COUNT;
      prv[e] = 0;
      free_ptr = e;
      count--;
   endfunction

   // note an accepted request: advance the state and queue the response it must give
   function void note_request(alle_pkg::req_item_type rq);
      int unsigned slot, r, pos, cur;
      alle_pkg::status_type st;
      alle_pkg::rsp_item_type ex;
      slot = 0; st = alle_pkg::ST_OK;
      r = 32'(rq.slot_ref); pos = 32'(rq.position);
      if (rq.opcode inside {alle_pkg::OP_INS_HEAD, alle_pkg::OP_INS_TAIL,
                            alle_pkg::OP_INS_AFTER, alle_pkg::OP_INS_BEFORE}
          && count >= alle_pkg::SLOT_COUNT - 1) begin
         st = alle_pkg::ST_FULL;
      end else if (rq.opcode == alle_pkg::OP_INS_HEAD) begin
         slot = put_head();
      end else if (rq.opcode == alle_pkg::OP_INS_TAIL) begin
         slot = put_tail();
      end else if (rq.opcode inside {alle_pkg::OP_INS_AFTER, alle_pkg::OP_INS_BEFORE,
                                     alle_pkg::OP_DELETE}) begin
         if (count == 0) st = alle_pkg::ST_EMPTY;
         else if (r == 0 || r >= alle_pkg::SLOT_COUNT) st = alle_pkg::ST_RANGE;
         else if (rq.opcode == alle_pkg::OP_INS_AFTER) slot = put_after(r);
         else if (rq.opcode == alle_pkg::OP_INS_BEFORE)
            slot = (r == head) ? put_head() : put_after(prv[r]);
         else begin
            unlink(r);
            slot = r;
         end
      end else if (rq.opcode == alle_pkg::OP_LOOKUP) begin
         if (count == 0) st = alle_pkg::ST_EMPTY;
         else if (pos == 0 || pos > count) st = alle_pkg::ST_RANGE;
         else if (linear) slot = pos;
         else begin
            cur = head;
            for (int i = 1; i < pos; i++) cur = nxt[cur];
            slot = cur;
         end
      end else begin
         st = alle_pkg::ST_RANGE;
      end
      case (st)
         alle_pkg::ST_OK:    n_ok++;
         alle_pkg::ST_FULL:  n_full++;
         alle_pkg::ST_EMPTY: n_empty++;
         default:            n_range++;
      endcase
      ex.slot_out = alle_pkg::SLOT_W'(slot);
      ex.status = st;
      pending_rsp.push_back(ex);
   endfunction

   function void check_response(alle_pkg::rsp_item_type got);
      alle_pkg::rsp_item_type ex;
      if (pending_rsp.size() == 0) begin
         $error("response with nothing expected: slot %0d status %0d",
                got.slot_out, got.status);
         errors++;
         return;
      end
      ex = pending_rsp.pop_front();
      if (got.slot_out !== ex.slot_out) begin
         $error("slot_out: expected %0d, actual %0d", ex.slot_out, got.slot_out);
         errors++;
      end
      if (got.status !== ex.status) begin
         $error("status: expected %0d, actual %0d", ex.status, got.status);
         errors++;
      end
   endfunction
endclass

module array_linked_list_engine_top_tb;

   localparam int N_RANDOM   = 640;
   localparam int STALL_LIMIT = 20000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   alle_pkg::req_item_type req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   alle_pkg::rsp_item_type rsp_item;

   list_scoreboard sb;
   bit   quiet;          // last part of the run: no idling on either side
   int   idle_cycles;    // cycles since the last accepted transaction
   int   n_sent;

   array_linked_list_engine_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sends one request transaction. A random idle burst may come first; valid is only
   // lowered when a gap follows, so back-to-back transactions keep it high. Stall is
   // looked at mid-cycle, where it shows what the next rising edge will see.
   task automatic send_request(input alle_pkg::req_item_type rq);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= rq;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sb.note_request(rq);
      n_sent++;
   endtask

   task automatic send_op(input alle_pkg::op_type op, input int unsigned ref_slot,
                          input int unsigned pos);
      alle_pkg::req_item_type rq;
      rq.opcode     = op;
      rq.item_value = $urandom;
      rq.slot_ref   = alle_pkg::SLOT_W'(ref_slot);
      rq.position   = alle_pkg::SLOT_W'(pos);
      send_request(rq);
   endtask

   // Picks a slot reference: mostly a live list member, sometimes anything.
   function automatic int unsigned pick_slot();
      int unsigned cur;
      int unsigned hops;
      if (sb.count == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
      cur = sb.head;
      hops = $urandom_range(0, sb.count - 1);
      for (int i = 0; i < hops; i++) cur = sb.nxt[cur];
      return cur;
   endfunction

   // Random phase: bias inserts or deletes so the list swings between empty and full.
   task automatic random_phase(input int n_items);
      bit grow;
      int unsigned roll;
      alle_pkg::op_type op;
      grow = 1;
      for (int k = 0; k < n_items; k++) begin
         if (sb.count >= alle_pkg::SLOT_COUNT - 1) grow = 0;
         else if (sb.count == 0) grow = 1;
         else if ($urandom_range(0, 39) == 0) grow = ~grow;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            // unknown opcode, raw bits
            alle_pkg::req_item_type rq;
            rq = $bits(alle_pkg::req_item_type)'({$urandom, $urandom});
            rq.opcode = alle_pkg::op_type'($urandom_range(6, 7));
            send_request(rq);
            continue;
         end
         if (roll < 25) op = alle_pkg::OP_LOOKUP;
         else if (grow ? roll < 35 : roll < 75) op = alle_pkg::OP_DELETE;
         else op = alle_pkg::op_type'($urandom_range(0, 3));
         send_op(op, pick_slot(),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(1, sb.count > 0 ? sb.count : 1));
      end
   endtask

   // Result side: random stall bursts; a response is checked mid-cycle before the
   // edge that takes it.
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_item);
         @(posedge clock);
         if (!quiet && !rsp_stall && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) begin
               @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: counts cycles with no transaction on either channel.
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[array_linked_list_engine_top] ERROR");
            $finish;
         end
      end
   end

   initial begin
      alle_pkg::req_item_type rq;
      sb = new();
      quiet = 0;
      n_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list cases, bad ranges, linear growth, unknown opcodes
      send_op(alle_pkg::OP_LOOKUP, 0, 1);
      send_op(alle_pkg::OP_DELETE, 1, 0);
      send_op(alle_pkg::OP_INS_AFTER, 1, 0);
      send_op(alle_pkg::OP_INS_BEFORE, 1, 0);
      rq = '1;
      rq.opcode = alle_pkg::op_type'(3'd6);
      send_request(rq);
      rq.opcode = alle_pkg::op_type'(3'd7);
      rq.item_value = '0;
      send_request(rq);
      rq = '0;
      rq.item_value = 32'sh7fffffff;
      rq.opcode = alle_pkg::OP_INS_TAIL;
      send_request(rq);
      rq.item_value = 32'sh80000000;
      send_request(rq);
      send_op(alle_pkg::OP_INS_TAIL, 0, 0);
      send_op(alle_pkg::OP_LOOKUP, 0, 2);
      send_op(alle_pkg::OP_LOOKUP, 0, 0);
      send_op(alle_pkg::OP_LOOKUP, 0, 63);
      send_op(alle_pkg::OP_DELETE, 0, 0);
      send_op(alle_pkg::OP_INS_AFTER, 63, 0);
      send_op(alle_pkg::OP_INS_AFTER, 3, 0);    // after the tail: taken as a tail insert
      send_op(alle_pkg::OP_INS_BEFORE, 1, 0);   // before the head
      send_op(alle_pkg::OP_INS_BEFORE, 3, 0);
      send_op(alle_pkg::OP_INS_HEAD, 0, 0);
      send_op(alle_pkg::OP_LOOKUP, 0, 4);       // walk now the list is scrambled
      send_op(alle_pkg::OP_DELETE, sb.tail, 0);
      send_op(alle_pkg::OP_DELETE, sb.head, 0);
      send_op(alle_pkg::OP_DELETE, 62, 0);      // stale reference to a free slot
      // fill to full with tail inserts, then one more insert at the head and one after a slot
      while (sb.count < alle_pkg::SLOT_COUNT - 1) send_op(alle_pkg::OP_INS_TAIL, 0, 0);
      send_op(alle_pkg::OP_INS_HEAD, 0, 0);
      send_op(alle_pkg::OP_INS_AFTER, 5, 0);
      send_op(alle_pkg::OP_LOOKUP, 0, 63);
      // drain to one element, then delete it by an arbitrary name
      while (sb.count > 1) send_op(alle_pkg::OP_DELETE, sb.head, 0);
      send_op(alle_pkg::OP_DELETE, 40, 0);

      random_phase(N_RANDOM * 3 / 4);
      quiet = 1;
      random_phase(N_RANDOM / 4);
      req_valid <= 1'b0;

      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("Sent %0d requests: %0d ok, %0d full, %0d empty, %0d out of range.",
               n_sent, sb.n_ok, sb.n_full, sb.n_empty, sb.n_range);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("[array_linked_list_engine_top] OK");
      end else begin
         $display("[array_linked_list_engine_top] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/alle_pkg.sv
rtl/core/alle_ram.sv
rtl/core/alle_slot_store.sv
rtl/core/alle_ctrl.sv
rtl/core/array_linked_list_engine_top.sv
tb/sv/array_linked_list_engine_top_tb.sv
